// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: invariant");

// Antecedent at one edge implies consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/tdeq_pkg.sv
package tdeq_pkg;

   // ring store geometry
   localparam int DEPTH  = 16;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // field widths
   localparam int OP_W      = 3;
   localparam int TAG_W     = 2;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 3;
   localparam int ENTRY_W   = TAG_W + VALUE_W;
   localparam int TDATA_W   = ((ENTRY_W + 7) / 8) * 8;
   localparam int TDATA_PAD = TDATA_W - ENTRY_W;

   localparam logic [TAG_W-1:0] TAG_NONE = 2'd0;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_DROP_FRONT = 3'd2,
      OP_DROP_BACK  = 3'd3,
      OP_LIST       = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE   = 3'd0,
      ST_LISTED = 3'd1,
      ST_EMPTY  = 3'd2,
      ST_FULL   = 3'd3,
      ST_BADTAG = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_LIST
   } state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [TAG_W-1:0]   tag;
   } entry_type;

   // controller to ring store
   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] waddr;
      entry_type         wdata;
      logic [SLOT_W-1:0] raddr;
   } ram_req_type;

   // (base + offset) modulo DEPTH, both operands below DEPTH
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                  input logic [SLOT_W-1:0] offset);
      logic [SLOT_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (SLOT_W+1)'(DEPTH)) begin
         sum = sum - (SLOT_W+1)'(DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

   // (base - 1) modulo DEPTH
   function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] base);
      logic [SLOT_W-1:0] res;
      if (base == '0) begin
         res = SLOT_W'(DEPTH - 1);
      end else begin
         res = base - SLOT_W'(1);
      end
      return res;
   endfunction

endpackage

// File: rtl/core/tdeq_ram.sv
module tdeq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tdeq_ctrl.sv
module tdeq_ctrl
   import tdeq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  op_type              req_op,
   input  logic [TAG_W-1:0]    req_tag,
   input  logic [VALUE_W-1:0]  req_payload,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output status_type          rsp_status,
   output logic [TAG_W-1:0]    rsp_tag,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic                rsp_last,
   output ram_req_type         ram_req,
   input  entry_type           rd_entry
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]  front_ff, front_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_free;
   logic               accept;
   logic               load;
   logic               list_end;

   // output register can take a new item
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign list_end   = (idx_ff == SLOT_W'(count_ff - CNT_W'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_op == OP_LIST && count_ff != '0) begin
               state_in = S_LIST;
            end
         end
         S_LIST: begin
            if (out_free && list_end) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and store access
   always_comb begin
      load          = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_tag_in    = TAG_NONE;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      count_in      = count_ff;
      front_in      = front_ff;
      idx_in        = '0;
      ram_req.we    = 1'b0;
      ram_req.waddr = front_ff;
      ram_req.wdata = '{value: req_payload, tag: req_tag};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               load = 1'b1;
               unique case (req_op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (req_tag == TAG_NONE) begin
                        rsp_status_in = ST_BADTAG;
                     end else if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ram_req.we = 1'b1;
                        count_in   = count_ff + CNT_W'(1);
                        if (req_op == OP_PUSH_FRONT) begin
                           front_in      = slot_dec(front_ff);
                           ram_req.waddr = front_in;
                        end else begin
                           ram_req.waddr = slot_add(front_ff, SLOT_W'(count_ff));
                        end
                     end
                  end
                  OP_DROP_FRONT, OP_DROP_BACK: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        if (req_op == OP_DROP_FRONT) begin
                           front_in = slot_add(front_ff, SLOT_W'(1));
                        end
                     end
                  end
                  OP_LIST: begin
                     // non-empty list streams from the store instead
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        load = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LIST: begin
            // read data always belongs to idx_ff: address follows idx_in
            idx_in = idx_ff;
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = ST_LISTED;
               rsp_tag_in    = rd_entry.tag;
               rsp_value_in  = rd_entry.value;
               rsp_last_in   = list_end;
               idx_in        = list_end ? '0 : idx_ff + SLOT_W'(1);
            end
         end
         default: ;
      endcase
      ram_req.raddr = slot_add(front_ff, idx_in);
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         front_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_tag_ff    <= rsp_tag_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_tag    = rsp_tag_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// File: rtl/core/tagged_double_ended_queue.sv
// Channel  Dir  Handshake             Contents
// req      in   req_tvalid/tready     tuser op; tdata tag, payload
// rsp      out  rsp_tvalid/tready     tuser status; tdata entry tag, value; tlast
//
// Push, drop and the empty-list case: one item per cycle while rsp is not stalled.
// A listing of N entries holds off req until its last entry is sent and sends one
// entry per cycle unless rsp stalls, set by the single read port of the ring store.
// Reset clears front slot, count and the result valid flag; no clearing pass.
// A stalled rsp holds its item; req is taken again once the result register
// drains or is taken in the same cycle.
`include "assert_macros.svh"

module tagged_double_ended_queue
   import tdeq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [OP_W-1:0]    req_tuser,   // op
   input  logic [TDATA_W-1:0] req_tdata,   // tag[1:0], payload[33:2], zero pad
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [STATUS_W-1:0] rsp_tuser,  // status
   output logic [TDATA_W-1:0] rsp_tdata,   // entry_tag[1:0], entry_value[33:2], pad
   output logic               rsp_tlast
);

   ram_req_type        ram_req;
   entry_type          rd_entry;
   status_type         rsp_status;
   logic [TAG_W-1:0]   rsp_tag;
   logic [VALUE_W-1:0] rsp_value;
   logic               req_take;
   logic               req_push;
   logic               req_single;

   tdeq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_op      (op_type'(req_tuser)),
      .req_tag     (req_tdata[TAG_W-1:0]),
      .req_payload (req_tdata[ENTRY_W-1:TAG_W]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_status  (rsp_status),
      .rsp_tag     (rsp_tag),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_tlast),
      .ram_req     (ram_req),
      .rd_entry    (rd_entry)
   );

   // ring store of tagged entries
   tdeq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.we),
      .wr_addr (ram_req.waddr),
      .wr_data (ram_req.wdata),
      .rd_addr (ram_req.raddr),
      .rd_data (rd_entry)
   );

   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {{TDATA_PAD{1'b0}}, rsp_value, rsp_tag};

   // accepted item kinds
   assign req_take   = req_tvalid && req_tready;
   assign req_push   = (req_tuser == OP_PUSH_FRONT) || (req_tuser == OP_PUSH_BACK);
   assign req_single = req_take && (req_tuser != OP_LIST);

   // store written only by an accepted push
   `ASSERT_IMPLIES(a_write_on_push, clock, reset, ram_req.we, req_take && req_push)
   // a non-list item always yields its result in the next cycle
   `ASSERT_NEXT(a_single_result, clock, reset, req_single, rsp_tvalid && rsp_tlast)
   // only listed entries may be non-final
   `ASSERT_IMPLIES(a_last_nonlist, clock, reset, rsp_tvalid && rsp_tuser != ST_LISTED, rsp_tlast)

endmodule
